>>> rtl/binary_trie_longest_prefix_match_top_assert.svh
// Assertion macros for the binary trie longest prefix match block.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTLPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/btlpm_pkg.sv
// Package with shared constants and types of the binary trie prefix match block.
package btlpm_pkg;

  localparam int POOL_NODES_DEF = 1024;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int ADDR_W     = 32;
  localparam int PLEN_W     = 6;
  localparam int LEN_W      = 6;
  localparam int IDX_W      = 10;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    SRC_ROOT,
    SRC_MEM,
    SRC_FRESH
  } src_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fin;
  } dp_status_t;

endpackage

>>> rtl/btlpm_ram.sv
// Generic single write port RAM with a registered read port.
module btlpm_ram
  import btlpm_pkg::*;
#(
  parameter int WIDTH = 21,
  parameter int DEPTH = POOL_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/btlpm_ctrl.sv
// Controller state machine that sequences the trie walk and the result handshake.
module btlpm_ctrl
  import btlpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.fin && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WALK: begin
        cmd.step = !sts.fin || out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.step && sts.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/btlpm_dp.sv
// Datapath with the node pool, the walk registers, the allocator and the result register.
module btlpm_dp
  import btlpm_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts,
  input  logic                  in_mode,
  input  logic [ADDR_W-1:0]     in_addr,
  input  logic [PLEN_W-1:0]     in_plen,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int IW = $clog2(POOL_NODES);
  localparam int FW = $clog2(POOL_NODES + 1);
  localparam int DW = $clog2(ADDR_BITS + 1);
  localparam int NW = 2 * IW + 1;

  logic                  mode_r;
  logic [ADDR_BITS-1:0]  addr_sh_r;
  logic [DW-1:0]         plen_r;
  logic [DW-1:0]         depth_r;
  logic [IW-1:0]         cur_r;
  src_t                  src_r;
  logic                  found_r;
  logic [DW-1:0]         best_len_r;
  logic [IW-1:0]         best_idx_r;
  logic [IW-1:0]         root_c0_r;
  logic [IW-1:0]         root_c1_r;
  logic [FW-1:0]         next_free_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [DW-1:0]         plen_sat;
  logic [NW-1:0]         nd;
  logic [NW-1:0]         nd_upd;
  logic [NW-1:0]         rdata;
  logic                  nd_mark;
  logic                  bit_b;
  logic [IW-1:0]         child;
  logic                  child_none;
  logic                  pool_exh;
  logic                  mark_here;
  logic                  fin;
  logic                  advance;
  logic                  alloc;
  logic                  res_hit;
  logic                  res_full;
  logic [DW-1:0]         res_len;
  logic [IW-1:0]         res_idx;
  logic                  we;
  logic [NW-1:0]         wdata;
  logic                  mem_we;
  logic                  mem_re;

  always_comb begin
    if (int'(in_plen) > ADDR_BITS) begin
      plen_sat = DW'(ADDR_BITS);
    end else begin
      plen_sat = DW'(in_plen);
    end
  end

  always_comb begin
    case (src_r)
      SRC_ROOT:  nd = {1'b0, root_c1_r, root_c0_r};
      SRC_MEM:   nd = rdata;
      default:   nd = '0;
    endcase
  end

  assign nd_mark    = nd[NW-1];
  assign bit_b      = addr_sh_r[ADDR_BITS-1];
  assign child      = bit_b ? nd[2*IW-1:IW] : nd[IW-1:0];
  assign child_none = (child == '0);
  assign pool_exh   = (next_free_r >= FW'(POOL_NODES));
  assign mark_here  = (src_r == SRC_MEM) && nd_mark;

  always_comb begin
    nd_upd = nd;
    if (bit_b) begin
      nd_upd[2*IW-1:IW] = IW'(next_free_r);
    end else begin
      nd_upd[IW-1:0] = IW'(next_free_r);
    end
  end

  always_comb begin
    fin      = 1'b0;
    advance  = 1'b0;
    alloc    = 1'b0;
    res_hit  = 1'b0;
    res_full = 1'b0;
    res_len  = '0;
    res_idx  = '0;
    we       = 1'b0;
    wdata    = nd;
    if (mode_r == MODE_LOOKUP) begin
      res_hit = found_r || mark_here;
      res_len = mark_here ? depth_r : best_len_r;
      res_idx = mark_here ? cur_r : best_idx_r;
      if ((depth_r == DW'(ADDR_BITS)) || child_none) begin
        fin = 1'b1;
      end else begin
        advance = 1'b1;
      end
    end else if (plen_r == '0) begin
      fin = 1'b1;
    end else if (depth_r == plen_r) begin
      fin       = 1'b1;
      res_hit   = 1'b1;
      res_len   = depth_r;
      res_idx   = cur_r;
      we        = 1'b1;
      wdata     = nd;
      wdata[NW-1] = 1'b1;
    end else if (!child_none) begin
      advance = 1'b1;
    end else if (pool_exh) begin
      fin      = 1'b1;
      res_full = 1'b1;
      we       = (cur_r != '0);
    end else begin
      alloc = 1'b1;
      we    = (cur_r != '0);
      wdata = nd_upd;
    end
  end

  assign sts.fin = fin;
  assign mem_we  = cmd.step && we;
  assign mem_re  = cmd.step && advance;

  btlpm_ram #(
    .WIDTH (NW),
    .DEPTH (POOL_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_r),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (child),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= FW'(1);
      root_c0_r   <= '0;
      root_c1_r   <= '0;
    end else if (cmd.step && alloc) begin
      next_free_r <= next_free_r + FW'(1);
      if (cur_r == '0) begin
        if (bit_b) begin
          root_c1_r <= IW'(next_free_r);
        end else begin
          root_c0_r <= IW'(next_free_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      addr_sh_r  <= ADDR_BITS'(in_addr);
      plen_r     <= plen_sat;
      depth_r    <= '0;
      cur_r      <= '0;
      src_r      <= SRC_ROOT;
      found_r    <= 1'b0;
      best_len_r <= '0;
      best_idx_r <= '0;
    end else if (cmd.step && (advance || alloc)) begin
      addr_sh_r <= addr_sh_r << 1;
      depth_r   <= depth_r + DW'(1);
      if (advance) begin
        cur_r <= child;
        src_r <= SRC_MEM;
      end else begin
        cur_r <= IW'(next_free_r);
        src_r <= SRC_FRESH;
      end
      if (mark_here) begin
        found_r    <= 1'b1;
        best_len_r <= depth_r;
        best_idx_r <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && fin) begin
      out_data_r <= {6'b0, IDX_W'(res_idx), LEN_W'(res_len), res_full, res_hit};
    end
  end

  assign out_data = out_data_r;

endmodule

>>> rtl/binary_trie_longest_prefix_match_top.sv
// An item is accepted in ST_IDLE; ST_WALK then steps down one trie level at a time and
// ends with a final step that registers the result, which can stall on a full output.
// Throughput is set by the single node memory read per level; the result register lets
// the next transaction be accepted while a result waits on the output.
// Reset clears the allocator to one node and the root's children; pool nodes are written
// as they are allocated, so there is no clearing pass.
module binary_trie_longest_prefix_match_top
  import btlpm_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // addr[31:0], prefix_len[37:32], zero fill
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // hit, pool_full, match_len, node_index, zero fill
);

  `include "binary_trie_longest_prefix_match_top_assert.svh"

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  btlpm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  btlpm_dp #(
    .POOL_NODES (POOL_NODES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_mode  (in_tuser),
    .in_addr  (in_tdata[ADDR_W-1:0]),
    .in_plen  (in_tdata[ADDR_W+PLEN_W-1:ADDR_W]),
    .out_data (out_tdata)
  );

  `BTLPM_ASSERT_NOW(a_full_no_hit, out_tvalid && out_tdata[1], !out_tdata[0] && (out_tdata[7:2] == 6'd0), "pool full result reports a match")
  `BTLPM_ASSERT_NEXT(a_load_busy, cmd.load, !in_tready, "block ready right after accepting a transaction")
  `BTLPM_ASSERT_NEXT(a_fin_valid, cmd.step && sts.fin, out_tvalid, "finished walk did not present a result")

endmodule
